@@ sv/tcw_pkg.sv @@
// Package for the text console writer: item structs, kind codes, glyph codes
// and default geometry. No dependencies; used by every file of the block.
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] GLYPH_NEWLINE = 8'd10;
  localparam logic [7:0] GLYPH_RETURN  = 8'd13;
  localparam logic [7:0] GLYPH_SPACE   = 8'h20;

  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] cell_value;
    logic        scrolled;
    logic        dropped;
  } out_item_t;

endpackage

@@ sv/tcw_cursor_step.sv @@
// Cursor advance for one put-character item: newline, return, wrap, scroll.
// Depends on tcw_pkg for glyph codes.
module tcw_cursor_step #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  localparam int RW = $clog2(ROWS),
  localparam int CW = $clog2(COLS)
) (
  input  logic [7:0]    ch,
  input  logic [RW-1:0] row_i,
  input  logic [CW-1:0] col_i,
  output logic [RW-1:0] row_o,
  output logic [CW-1:0] col_o,
  output logic          store_o,
  output logic          scroll_o
);

  logic [CW:0] col_inc;
  logic [RW:0] row_new;

  always_comb begin
    col_inc  = {1'b0, col_i} + (CW+1)'(1);
    row_new  = {1'b0, row_i};
    col_o    = col_i;
    store_o  = 1'b0;
    if (ch == tcw_pkg::GLYPH_NEWLINE) begin
      col_o   = '0;
      row_new = {1'b0, row_i} + (RW+1)'(1);
    end else if (ch == tcw_pkg::GLYPH_RETURN) begin
      col_o = '0;
    end else begin
      store_o = 1'b1;
      if (col_inc == (CW+1)'(COLS)) begin
        col_o   = '0;
        row_new = {1'b0, row_i} + (RW+1)'(1);
      end else begin
        col_o = col_inc[CW-1:0];
      end
    end
    // stepping past the bottom row scrolls; cursor stays on the bottom row
    scroll_o = (row_new == (RW+1)'(ROWS));
    row_o    = scroll_o ? RW'(ROWS - 1) : row_new[RW-1:0];
  end

endmodule

@@ sv/text_console_writer_unit.sv @@
// Text console writer: put-character, clear and read of a ROWS x COLS cell store.
// Path from accept: put S_ADDR, S_WRITE, S_DONE; in-range read S_ADDR, S_READ, S_DONE;
// dropped put, out-of-range read or unused kind S_DONE; clear S_CLR, S_DONE; scrolling put
// adds S_SCRL, S_BLANK. The result is valid on return to idle; a held result stalls S_DONE.
// Scroll and clear walk the store one cell a cycle through its single write port.
// Reset (rst_n low, synchronous): cursor home, console disabled, attribute 0x0F;
// the cell store is not cleared by reset, a clear item fills it.
module text_console_writer_unit #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  localparam int N  = ROWS * COLS;
  localparam int AW = $clog2(N);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(N - 1);
  localparam logic [AW-1:0] COPY_END  = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLS);

  typedef enum logic [2:0] {
    S_IDLE, S_ADDR, S_READ, S_WRITE, S_SCRL, S_BLANK, S_CLR, S_DONE
  } state_t;

  state_t             state_r;
  tcw_pkg::in_item_t  item_r;
  tcw_pkg::out_item_t out_r;
  logic               out_valid_r;
  logic [RW-1:0]      row_r;
  logic [CW-1:0]      col_r;
  logic               enabled_r;
  logic [7:0]         attr_r;
  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      cnt_r;
  logic               hit_r;
  logic               scrolled_r;
  logic               dropped_r;

  logic [15:0]   mem [N];
  logic [15:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  logic [RW-1:0] step_row;
  logic [CW-1:0] step_col;
  logic          step_store;
  logic          step_scroll;
  logic [AW-1:0] row_ext;
  logic [AW-1:0] col_ext;
  logic [15:0]   blank;

  tcw_cursor_step #(.COLS(COLS), .ROWS(ROWS)) u_step (
    .ch      (item_r.char_code),
    .row_i   (row_r),
    .col_i   (col_r),
    .row_o   (step_row),
    .col_o   (step_col),
    .store_o (step_store),
    .scroll_o(step_scroll)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign blank     = {attr_r, tcw_pkg::GLYPH_SPACE};

  always_comb begin
    if (item_r.kind == tcw_pkg::KIND_READ) begin
      row_ext = AW'(item_r.read_row);
      col_ext = AW'(item_r.read_col);
    end else begin
      row_ext = AW'(row_r);
      col_ext = AW'(col_r);
    end
  end

  // store port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r;
    mem_wd = blank;
    mem_re = 1'b0;
    mem_ra = addr_r;
    unique case (state_r)
      S_WRITE: begin
        mem_we = step_store;
        mem_wa = addr_r;
        mem_wd = {attr_r, item_r.char_code};
      end
      S_SCRL: begin
        // read one row ahead, write the cell read last cycle one slot back
        mem_re = (cnt_r != COPY_END);
        mem_ra = cnt_r + COLS_A;
        mem_we = (cnt_r != '0);
        mem_wa = cnt_r - AW'(1);
        mem_wd = rd_data_r;
      end
      S_BLANK, S_CLR: begin
        mem_we = 1'b1;
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      enabled_r   <= 1'b0;
      attr_r      <= tcw_pkg::ATTR_RESET;
    end else begin
      if (cfg_we) attr_r <= cfg_wdata;
      // S_DONE handles its own handover of the result register
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r     <= in_item;
            hit_r      <= 1'b0;
            scrolled_r <= 1'b0;
            dropped_r  <= 1'b0;
            cnt_r      <= '0;
            unique case (in_item.kind)
              tcw_pkg::KIND_PUT: begin
                if (enabled_r) begin
                  state_r <= S_ADDR;
                end else begin
                  dropped_r <= 1'b1;
                  state_r   <= S_DONE;
                end
              end
              tcw_pkg::KIND_CLEAR: state_r <= S_CLR;
              tcw_pkg::KIND_READ: begin
                if ((int'(in_item.read_row) < ROWS) && (int'(in_item.read_col) < COLS)) begin
                  hit_r   <= 1'b1;
                  state_r <= S_ADDR;
                end else begin
                  state_r <= S_DONE;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_ADDR: begin
          addr_r  <= row_ext * COLS_A + col_ext;
          state_r <= (item_r.kind == tcw_pkg::KIND_READ) ? S_READ : S_WRITE;
        end
        S_READ: state_r <= S_DONE;
        S_WRITE: begin
          row_r      <= step_row;
          col_r      <= step_col;
          scrolled_r <= step_scroll;
          state_r    <= step_scroll ? S_SCRL : S_DONE;
        end
        S_SCRL: begin
          if (cnt_r == COPY_END) begin
            state_r <= S_BLANK;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        S_BLANK: begin
          if (cnt_r == LAST_CELL) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        S_CLR: begin
          if (cnt_r == LAST_CELL) begin
            row_r     <= '0;
            col_r     <= '0;
            enabled_r <= 1'b1;
            state_r   <= S_DONE;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.cursor_row <= tcw_pkg::OUT_ROW_W'(row_r);
            out_r.cursor_col <= tcw_pkg::OUT_COL_W'(col_r);
            out_r.cell_value <= hit_r ? rd_data_r : 16'd0;
            out_r.scrolled   <= scrolled_r;
            out_r.dropped    <= dropped_r;
            out_valid_r      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/tcw_checker.sv @@
// Port-level checks for text_console_writer_unit, bound to the top level.
// Depends on tcw_pkg for the item structs.
module tcw_checker #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tcw_pkg::out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted an item while busy");

  // a dropped item neither scrolls nor returns a cell
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.dropped |-> !out_item.scrolled && out_item.cell_value == 16'd0)
    else $error("dropped item carries data");

  // a scroll leaves the cursor at column 0 of the bottom row
  a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.scrolled |->
      out_item.cursor_col == 7'd0 && out_item.cursor_row == 5'(ROWS - 1))
    else $error("cursor not on bottom row after scroll");

  // cursor stays inside the screen
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ROWS > 32 || int'(out_item.cursor_row) < ROWS) &&
                  (COLS > 128 || int'(out_item.cursor_col) < COLS))
    else $error("cursor out of range");

endmodule

bind text_console_writer_unit tcw_checker #(.COLS(COLS), .ROWS(ROWS)) u_tcw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);
